FILE: rtl/rmfw_pkg.sv
// package for the recursive mutex with fifo waiter queue
// holds sizes, status codes and the structs shared by the modules
// no dependencies
`default_nettype none
package rmfw_pkg;

	localparam int THREAD_COUNT = 16;
	localparam int MAX_DEPTH    = 255;
	localparam int RING_SLOTS   = 16;

	localparam int TID_W   = 4;
	localparam int DEPTH_W = 8;
	localparam int STAT_W  = 4;
	localparam int PTR_W   = $clog2(RING_SLOTS);
	localparam int CNT_W   = $clog2(RING_SLOTS + 1);

	// hold depth limit, capped by the width of the depth register
	localparam int DEPTH_CAP = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STAT_W-1:0] ST_ACQUIRED    = 4'd0;
	localparam logic [STAT_W-1:0] ST_NESTED      = 4'd1;
	localparam logic [STAT_W-1:0] ST_QUEUED      = 4'd2;
	localparam logic [STAT_W-1:0] ST_DEPTH_DOWN  = 4'd3;
	localparam logic [STAT_W-1:0] ST_HANDED_OVER = 4'd4;
	localparam logic [STAT_W-1:0] ST_FREED       = 4'd5;
	localparam logic [STAT_W-1:0] ST_NOT_OWNER   = 4'd6;
	localparam logic [STAT_W-1:0] ST_WAIT_REFUSE = 4'd7;
	localparam logic [STAT_W-1:0] ST_DEPTH_OVF   = 4'd8;

	// commands from the lock controller to the waiter queue
	typedef struct packed {
		logic             rd_en;
		logic             push;
		logic             pop;
		logic [TID_W-1:0] push_tid;
	} q_cmd_t;

	// queue status seen by the lock controller
	typedef struct packed {
		logic [CNT_W-1:0]        count;
		logic [THREAD_COUNT-1:0] flags;
		logic [TID_W-1:0]        head_tid;
	} q_stat_t;

	// one result
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               grant_valid;
		logic [TID_W-1:0]   grant_thread;
		logic [DEPTH_W-1:0] depth;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/rmfw_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module rmfw_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rmfw_queue.sv
// fifo queue of waiting threads: ring pointers, count, waiting flags
// depends on rmfw_pkg and rmfw_ram (ring storage)
`default_nettype none
module rmfw_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  rmfw_pkg::q_cmd_t cmd,
	output rmfw_pkg::q_stat_t stat
);
	import rmfw_pkg::*;

	logic [PTR_W-1:0]        head_q;
	logic [PTR_W-1:0]        tail_q;
	logic [CNT_W-1:0]        count_q;
	logic [THREAD_COUNT-1:0] flags_q;
	logic [TID_W-1:0]        head_data;

	// ring storage, head entry read on request accept
	rmfw_ram #(
		.WIDTH(TID_W),
		.DEPTH(RING_SLOTS)
	) u_ring (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(tail_q),
		.wdata(cmd.push_tid),
		.re   (cmd.rd_en),
		.raddr(head_q),
		.rdata(head_data)
	);

	// pointer, count and flag update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			flags_q <= '0;
		end else if (cmd.push) begin
			tail_q                <= tail_q + PTR_W'(1);
			count_q               <= count_q + CNT_W'(1);
			flags_q[cmd.push_tid] <= 1'b1;
		end else if (cmd.pop) begin
			head_q             <= head_q + PTR_W'(1);
			count_q            <= count_q - CNT_W'(1);
			flags_q[head_data] <= 1'b0;
		end
	end

	assign stat.count    = count_q;
	assign stat.flags    = flags_q;
	assign stat.head_tid = head_data;

endmodule
`default_nettype wire

FILE: rtl/rmfw_ctrl.sv
// lock controller: owner registers and the per request decision
// depends on rmfw_pkg; drives the waiter queue through q_cmd_t
`default_nettype none
module rmfw_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_fire,
	input  wire                       op_in,
	input  wire [rmfw_pkg::TID_W-1:0] tid_in,
	input  wire                       done,
	input  rmfw_pkg::q_stat_t         qstat,
	output logic                      busy,
	output rmfw_pkg::q_cmd_t          qcmd,
	output rmfw_pkg::result_t         res
);
	import rmfw_pkg::*;

	logic               valid_s1;
	logic               op_s1;
	logic [TID_W-1:0]   tid_s1;
	logic               held_q;
	logic [TID_W-1:0]   owner_q;
	logic [DEPTH_W-1:0] depth_q;

	logic               nxt_held;
	logic [TID_W-1:0]   nxt_owner;
	logic [DEPTH_W-1:0] nxt_depth;
	logic               known;
	logic               push;
	logic               pop;

	// request stage, ring head read is issued alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= op_in;
			tid_s1 <= tid_in;
		end
	end

	// decision for the request in stage one
	always_comb begin
		known        = 32'(tid_s1) < THREAD_COUNT;
		nxt_held     = held_q;
		nxt_owner    = owner_q;
		nxt_depth    = depth_q;
		push         = 1'b0;
		pop          = 1'b0;
		res.status       = ST_ACQUIRED;
		res.grant_valid  = 1'b0;
		res.grant_thread = '0;
		if (op_s1 == OP_ACQUIRE) begin
			if (!known) begin
				res.status = ST_WAIT_REFUSE;
			end else if (!held_q) begin
				nxt_held         = 1'b1;
				nxt_owner        = tid_s1;
				nxt_depth        = DEPTH_W'(1);
				res.status       = ST_ACQUIRED;
				res.grant_valid  = 1'b1;
				res.grant_thread = tid_s1;
			end else if (owner_q == tid_s1) begin
				if (32'(depth_q) >= DEPTH_CAP) begin
					res.status = ST_DEPTH_OVF;
				end else begin
					nxt_depth  = depth_q + DEPTH_W'(1);
					res.status = ST_NESTED;
				end
			end else if (qstat.flags[tid_s1] || (32'(qstat.count) >= RING_SLOTS)) begin
				res.status = ST_WAIT_REFUSE;
			end else begin
				push       = 1'b1;
				res.status = ST_QUEUED;
			end
		end else begin
			if (!known || !held_q || (owner_q != tid_s1)) begin
				res.status = ST_NOT_OWNER;
			end else if (depth_q > DEPTH_W'(1)) begin
				nxt_depth  = depth_q - DEPTH_W'(1);
				res.status = ST_DEPTH_DOWN;
			end else if (qstat.count != '0) begin
				pop              = 1'b1;
				nxt_owner        = qstat.head_tid;
				nxt_depth        = DEPTH_W'(1);
				res.status       = ST_HANDED_OVER;
				res.grant_valid  = 1'b1;
				res.grant_thread = qstat.head_tid;
			end else begin
				nxt_held   = 1'b0;
				nxt_owner  = '0;
				nxt_depth  = '0;
				res.status = ST_FREED;
			end
		end
		res.depth = nxt_depth;
	end

	// owner state commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			owner_q <= '0;
			depth_q <= '0;
		end else if (done) begin
			held_q  <= nxt_held;
			owner_q <= nxt_owner;
			depth_q <= nxt_depth;
		end
	end

	assign busy          = valid_s1;
	assign qcmd.rd_en    = in_fire;
	assign qcmd.push     = done && push;
	assign qcmd.pop      = done && pop;
	assign qcmd.push_tid = tid_s1;

endmodule
`default_nettype wire

FILE: rtl/recursive_mutex_fifo_waiters_top.sv
// recursive mutex with fifo waiter queue, top level
// a result passes the request stage and is then registered in the output register
// a new request is taken only once the one in flight is finished; the ring head read comes ahead of the decision
// a finished result may wait in the output register while the next request is taken
// reset: asynchronous active low, lock free and queue empty; ring contents not cleared
// depends on rmfw_pkg, rmfw_ctrl, rmfw_queue
`default_nettype none
module recursive_mutex_fifo_waiters_top (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         operation,
	input  wire [rmfw_pkg::TID_W-1:0]   thread_id,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [rmfw_pkg::STAT_W-1:0] status,
	output logic                        grant_valid,
	output logic [rmfw_pkg::TID_W-1:0]  grant_thread,
	output logic [rmfw_pkg::DEPTH_W-1:0] hold_depth_out
);
	import rmfw_pkg::*;

	logic    busy;
	logic    in_fire;
	logic    done;
	q_cmd_t  qcmd;
	q_stat_t qstat;
	result_t res;
	logic    out_valid_q;
	result_t res_q;

	// handshake: one request in flight, output register parts the sides
	assign in_stall = busy;
	assign in_fire  = in_valid && !busy;
	assign done     = busy && (!out_valid_q || !out_stall);

	rmfw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_fire(in_fire),
		.op_in  (operation),
		.tid_in (thread_id),
		.done   (done),
		.qstat  (qstat),
		.busy   (busy),
		.qcmd   (qcmd),
		.res    (res)
	);

	rmfw_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (qcmd),
		.stat  (qstat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign grant_valid    = res_q.grant_valid;
	assign grant_thread   = res_q.grant_thread;
	assign hold_depth_out = res_q.depth;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// testbench for recursive_mutex_fifo_waiters_top: lock and release requests with random gaps
// a scoreboard class predicts each result from its own copy of the lock and waiter queue
// depends on rmfw_pkg and recursive_mutex_fifo_waiters_top
module tb_top;
	import rmfw_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	// lock state mirror and the results it predicts
	class lock_scoreboard;
		logic                    held;
		logic [TID_W-1:0]        owner;
		logic [DEPTH_W-1:0]      depth;
		logic [TID_W-1:0]        ring [RING_SLOTS];
		logic [PTR_W-1:0]        head;
		logic [PTR_W-1:0]        tail;
		logic [CNT_W-1:0]        count;
		logic [THREAD_COUNT-1:0] waiting;
		result_t                 lock_outcomes [$];
		int                      errors;

		function new();
			held    = 1'b0;
			owner   = '0;
			depth   = '0;
			head    = '0;
			tail    = '0;
			count   = '0;
			waiting = '0;
			errors  = 0;
		endfunction

		function int pending();
			return lock_outcomes.size();
		endfunction

		task report(string what);
			if (errors < 40)
				$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		// apply one accepted request and queue the result it must give
		function void note_request(logic op, logic [TID_W-1:0] tid);
			result_t          r;
			logic [TID_W-1:0] heir;
			r = '0;
			if (op == OP_ACQUIRE) begin
				if (int'(tid) >= THREAD_COUNT) begin
					r.status = ST_WAIT_REFUSE;
				end else if (!held) begin
					held = 1'b1;
					owner = tid;
					depth = DEPTH_W'(1);
					r.status = ST_ACQUIRED;
					r.grant_valid = 1'b1;
					r.grant_thread = tid;
				end else if (owner == tid) begin
					if (int'(depth) >= DEPTH_CAP) begin
						r.status = ST_DEPTH_OVF;
					end else begin
						depth = depth + 1'b1;
						r.status = ST_NESTED;
					end
				end else if (waiting[tid] || int'(count) >= RING_SLOTS) begin
					r.status = ST_WAIT_REFUSE;
				end else begin
					ring[tail] = tid;
					tail = tail + 1'b1;
					count = count + 1'b1;
					waiting[tid] = 1'b1;
					r.status = ST_QUEUED;
				end
			end else begin
				if (int'(tid) >= THREAD_COUNT || !held || owner != tid) begin
					r.status = ST_NOT_OWNER;
				end else if (depth > 1) begin
					depth = depth - 1'b1;
					r.status = ST_DEPTH_DOWN;
				end else if (count > 0) begin
					// final release goes straight to the oldest waiter
					heir = ring[head];
					head = head + 1'b1;
					count = count - 1'b1;
					waiting[heir] = 1'b0;
					owner = heir;
					depth = DEPTH_W'(1);
					r.status = ST_HANDED_OVER;
					r.grant_valid = 1'b1;
					r.grant_thread = heir;
				end else begin
					held = 1'b0;
					owner = '0;
					depth = '0;
					r.status = ST_FREED;
				end
			end
			r.depth = depth;
			lock_outcomes.push_back(r);
		endfunction

		// compare one accepted result with the oldest prediction
		task check_result(result_t got);
			result_t want;
			if (lock_outcomes.size() == 0) begin
				report($sformatf("result with nothing predicted, status %0d", got.status));
				return;
			end
			want = lock_outcomes.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, predicted %0d", got.status, want.status));
			if (got.grant_valid !== want.grant_valid)
				report($sformatf("grant_valid %0b, predicted %0b",
					got.grant_valid, want.grant_valid));
			if (got.grant_thread !== want.grant_thread)
				report($sformatf("grant_thread %0d, predicted %0d",
					got.grant_thread, want.grant_thread));
			if (got.depth !== want.depth)
				report($sformatf("hold_depth_out %0d, predicted %0d", got.depth, want.depth));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 operation = OP_ACQUIRE;
	logic [TID_W-1:0]     thread_id = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [STAT_W-1:0]    status;
	logic                 grant_valid;
	logic [TID_W-1:0]     grant_thread;
	logic [DEPTH_W-1:0]   hold_depth_out;

	lock_scoreboard sb = new();
	int calm_items = 0;
	int stall_left = 0;
	int ready_left = 0;
	int stall_pick;
	int idle_cycles = 0;

	recursive_mutex_fifo_waiters_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.thread_id      (thread_id),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.grant_valid    (grant_valid),
		.grant_thread   (grant_thread),
		.hold_depth_out (hold_depth_out)
	);

	always #6 clk = ~clk;

	// reset once at the start
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// gap before the next request: mostly none or short, a few long, calm stretches
	function automatic int sender_gap();
		int r;
		if (calm_items > 0) begin
			calm_items--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r == 0)
			calm_items = $urandom_range(30, 80);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// drive one request and hold it until taken
	task automatic send_request(input logic op, input logic [TID_W-1:0] tid);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		thread_id <= tid;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(op, tid);
	endtask

	// hold off until every predicted result has come back
	task automatic drain_pause();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// every thread asks for the lock in random order
	task automatic queue_burst();
		logic [TID_W-1:0] order [THREAD_COUNT];
		logic [TID_W-1:0] swap;
		int j;
		for (int i = 0; i < THREAD_COUNT; i++)
			order[i] = i[TID_W-1:0];
		for (int i = THREAD_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		for (int i = 0; i < THREAD_COUNT; i++)
			send_request(OP_ACQUIRE, order[i]);
	endtask

	// owner nests past the depth limit, then unwinds to the last release
	task automatic deep_nest();
		logic [TID_W-1:0] boss;
		int extra;
		if (!sb.held)
			send_request(OP_ACQUIRE, TID_W'($urandom_range(0, THREAD_COUNT - 1)));
		boss = sb.owner;
		send_request(OP_ACQUIRE, boss ^ 4'h5);
		extra = DEPTH_CAP - int'(sb.depth) + 2;
		repeat (extra) send_request(OP_ACQUIRE, boss);
		extra = int'(sb.depth);
		repeat (extra) send_request(OP_RELEASE, boss);
	endtask

	// random request shaped by the current lock state
	task automatic random_request();
		int r;
		logic op;
		logic [TID_W-1:0] tid;
		r = $urandom_range(0, 99);
		tid = TID_W'($urandom_range(0, THREAD_COUNT - 1));
		op = OP_ACQUIRE;
		if (!sb.held) begin
			if (r >= 80)
				op = OP_RELEASE;
		end else if (r < 25) begin
			op = OP_ACQUIRE;
		end else if (r < 55) begin
			op = OP_RELEASE;
			tid = sb.owner;
		end else if (r < 65) begin
			tid = sb.owner;
		end else begin
			op = $urandom_range(0, 1) ? OP_RELEASE : OP_ACQUIRE;
		end
		send_request(op, tid);
	endtask

	// stimulus and end of run
	initial begin
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);

		// directed: every status but depth overflow, thread extremes, release of a free lock
		send_request(OP_ACQUIRE, 4'd0);
		send_request(OP_ACQUIRE, 4'd0);
		send_request(OP_RELEASE, 4'd0);
		send_request(OP_ACQUIRE, 4'd15);
		send_request(OP_ACQUIRE, 4'd15);
		send_request(OP_ACQUIRE, 4'd7);
		send_request(OP_RELEASE, 4'd9);
		send_request(OP_RELEASE, 4'd0);
		send_request(OP_RELEASE, 4'd0);
		send_request(OP_RELEASE, 4'd15);
		send_request(OP_RELEASE, 4'd7);
		send_request(OP_RELEASE, 4'd7);
		send_request(OP_RELEASE, 4'd0);
		send_request(OP_ACQUIRE, 4'd10);
		send_request(OP_RELEASE, 4'd10);
		drain_pause();

		// random part with queue bursts and one run to the depth limit
		for (int n = 0; n < 460; n++) begin
			if (n % 60 == 30)
				queue_burst();
			else if (n == 230)
				deep_nest();
			else
				random_request();
			if ($urandom_range(0, 99) < 2)
				drain_pause();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS recursive_mutex_fifo_waiters_top");
		else
			$display("FAIL recursive_mutex_fifo_waiters_top");
		$finish;
	end

	// receiver stall: short and long runs, some long ready stretches
	always @(posedge clk) begin
		if (stall_left == 0 && ready_left == 0) begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 5)
				stall_left = $urandom_range(8, 40);
			else if (stall_pick < 40)
				stall_left = $urandom_range(1, 3);
			else if (stall_pick < 45)
				ready_left = $urandom_range(60, 200);
			else
				ready_left = $urandom_range(1, 4);
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			ready_left--;
			out_stall <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{status, grant_valid, grant_thread, hold_depth_out});
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL recursive_mutex_fifo_waiters_top");
			$finish;
		end
	end

endmodule
